[rtl/cbmv_pkg.sv]
// Shared widths, register indexes and token types for the complex band matrix-vector multiplier.
package cbmv_pkg;

    localparam int ACC_W           = 40;
    localparam int ROW_W           = 16;
    localparam int N_W             = 17;
    localparam int BW_W            = 4;
    localparam int SLOT_W          = 5;
    localparam int CELL_ID_W       = 6;
    localparam int FLUSH_W         = 4;
    localparam int ROW_BIAS        = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 17;
    localparam int MAX_BAND_DEF    = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_N_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BW = 2'd2;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic                 upd;
        logic [CELL_ID_W-1:0] upd_id;
        acc_t                 add_re;
        acc_t                 add_im;
        logic                 rd;
        logic [CELL_ID_W-1:0] rd_id;
        logic [ROW_W-1:0]     row;
        logic                 last_row;
        logic                 clr;
        acc_t                 y_re;
        acc_t                 y_im;
    } token_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        acc_t             y_re;
        acc_t             y_im;
        logic             last_row;
    } result_t;

endpackage

[rtl/cbmv_cell.sv]
// One accumulator cell of the systolic row window: update, read-and-clear, pass the token on.
module cbmv_cell #(
    parameter int CELL_NUM = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  cbmv_pkg::token_t  tok_in,
    output cbmv_pkg::token_t  tok_out
);
    import cbmv_pkg::*;

    localparam logic [CELL_ID_W-1:0] MY_ID = CELL_ID_W'(CELL_NUM);

    acc_t   acc_re_reg, acc_im_reg;
    acc_t   acc_re_next, acc_im_next;
    acc_t   sum_re, sum_im;
    token_t tok_reg, tok_next;
    logic   hit_upd, hit_rd;

    assign hit_upd = tok_in.upd && (tok_in.upd_id == MY_ID);
    assign hit_rd  = tok_in.rd && (tok_in.rd_id == MY_ID);
    assign sum_re  = acc_re_reg + (hit_upd ? tok_in.add_re : '0);
    assign sum_im  = acc_im_reg + (hit_upd ? tok_in.add_im : '0);

    always_comb begin
        acc_re_next = sum_re;
        acc_im_next = sum_im;
        tok_next    = tok_in;
        if (hit_rd) begin
            tok_next.y_re = sum_re;
            tok_next.y_im = sum_im;
        end
        if (hit_rd || tok_in.clr) begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
            tok_reg    <= '0;
        end else if (adv) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/cbmv_out_buf.sv]
// Two-entry output buffer that parts the cell chain from the result channel.
module cbmv_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  cbmv_pkg::result_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    output cbmv_pkg::result_t out_data,
    input  logic              out_ready
);
    import cbmv_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/complex_band_matrix_vector_multiply.sv]
// Top level: band slot intake, multipliers, row sequencer, accumulator cell chain, output buffer.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------
//   s_      | s_valid / s_ready  | s_a_re, s_a_im, s_x_re, s_x_im
//   m_      | m_valid / m_ready  | m_row_index, m_y_re, m_y_im, m_last_row
//   cfg_    | cfg_wr_en          | cfg_index, cfg_wdata
//
// One band slot per cycle while the chain advances and no flush is pending. A row is registered
// in stage 1, the injection register, the MAX_BAND cells (one cell per cycle) and the output buffer.
// The final column of a vector emits up to 16 rows; intake waits while the extra rows are issued.
// Reset is synchronous and clears every cell's accumulator in the same cycle.
// The whole chain holds while a row at its end finds the output buffer full.
module complex_band_matrix_vector_multiply #(
    parameter int MAX_BAND    = cbmv_pkg::MAX_BAND_DEF,
    parameter int SAMPLE_BITS = cbmv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_a_re,
    input  logic signed [SAMPLE_BITS-1:0]        s_a_im,
    input  logic signed [SAMPLE_BITS-1:0]        s_x_re,
    input  logic signed [SAMPLE_BITS-1:0]        s_x_im,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [cbmv_pkg::ROW_W-1:0]    m_row_index,
    output logic signed [cbmv_pkg::ACC_W-1:0]    m_y_re,
    output logic signed [cbmv_pkg::ACC_W-1:0]    m_y_im,
    output logic                                 m_last_row,
    input  logic                                 cfg_wr_en,
    input  logic        [cbmv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [cbmv_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cbmv_pkg::*;

    localparam int IDX_W     = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;
    localparam int MOD_IN_W  = $clog2(MAX_BAND + 47);
    localparam int MOD_TAB_N = 2 ** MOD_IN_W;
    localparam int PROD_W    = 2 * SAMPLE_BITS;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BAND - 1);

    typedef logic [IDX_W-1:0] band_idx_t;
    typedef band_idx_t mod_tab_t [MOD_TAB_N];

    // entry v holds (v - ROW_BIAS) mod MAX_BAND
    function automatic mod_tab_t build_mod_tab();
        mod_tab_t tab;
        int       r;
        r = 0;
        for (int j = 0; j < ROW_BIAS; j++) begin
            r = (r == 0) ? MAX_BAND - 1 : r - 1;
        end
        for (int i = 0; i < MOD_TAB_N; i++) begin
            tab[i] = IDX_W'(r);
            r = (r == MAX_BAND - 1) ? 0 : r + 1;
        end
        return tab;
    endfunction

    localparam mod_tab_t MOD_TAB = build_mod_tab();

    // configuration
    logic [N_W-1:0]  n_size_reg;
    logic [BW_W-1:0] lower_bw_reg, upper_bw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_size_reg   <= N_W'(1);
            lower_bw_reg <= '0;
            upper_bw_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_N_SIZE:   n_size_reg   <= cfg_wdata[N_W-1:0];
                REG_LOWER_BW: lower_bw_reg <= cfg_wdata[BW_W-1:0];
                REG_UPPER_BW: upper_bw_reg <= cfg_wdata[BW_W-1:0];
                default: ;
            endcase
        end
    end

    // intake: slot position and flush plan
    logic [ROW_W-1:0]    col_reg;
    logic [SLOT_W-1:0]   slot_reg;
    band_idx_t           cmod_reg;
    logic [ROW_W-1:0]    nm1;
    logic [SLOT_W-1:0]   band_w;
    logic                col_end, last_col;
    logic signed [N_W:0] row_s, lo_s, diff_s;
    logic                upd_item, rd_item;
    logic [ROW_W-1:0]    lo_row;
    logic [MOD_IN_W-1:0] upd_v, lo_v;
    band_idx_t           upd_idx, lo_idx;
    logic [FLUSH_W-1:0]  rem_item;
    logic                s_acc, chain_adv, s1_done;

    always_comb begin
        if (n_size_reg == '0) begin
            nm1 = '0;
        end else if (n_size_reg[N_W-1]) begin
            nm1 = '1;
        end else begin
            nm1 = n_size_reg[ROW_W-1:0] - ROW_W'(1);
        end
    end

    assign band_w   = SLOT_W'(lower_bw_reg) + SLOT_W'(upper_bw_reg) + SLOT_W'(1);
    assign col_end  = ({1'b0, slot_reg} + (SLOT_W+1)'(1)) >= {1'b0, band_w};
    assign last_col = col_reg >= nm1;

    assign row_s = $signed({2'b00, col_reg}) - $signed((N_W+1)'(upper_bw_reg))
                 + $signed((N_W+1)'(slot_reg));
    assign lo_s  = $signed({2'b00, col_reg}) - $signed((N_W+1)'(upper_bw_reg));

    assign upd_item = !row_s[N_W] && (row_s[N_W-1:0] <= {1'b0, nm1});
    assign upd_v    = MOD_IN_W'(cmod_reg) + MOD_IN_W'(slot_reg) + MOD_IN_W'(ROW_BIAS)
                    - MOD_IN_W'(upper_bw_reg);
    assign lo_v     = MOD_IN_W'(cmod_reg) + MOD_IN_W'(ROW_BIAS) - MOD_IN_W'(upper_bw_reg);
    assign upd_idx  = MOD_TAB[upd_v];
    assign lo_idx   = lo_s[N_W] ? '0 : MOD_TAB[lo_v];
    assign lo_row   = lo_s[N_W] ? '0 : lo_s[ROW_W-1:0];
    assign diff_s   = $signed({2'b00, nm1}) - $signed({2'b00, lo_row});

    always_comb begin
        rd_item  = 1'b0;
        rem_item = '0;
        if (col_end) begin
            if (last_col) begin
                rd_item = !diff_s[N_W];
                if (diff_s[N_W-1:FLUSH_W] != '0) begin
                    rem_item = '1;
                end else begin
                    rem_item = diff_s[FLUSH_W-1:0];
                end
            end else begin
                rd_item = !lo_s[N_W];
            end
        end
    end

    assign s_ready = chain_adv && s1_done;
    assign s_acc   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            slot_reg <= '0;
            cmod_reg <= '0;
        end else if (s_acc) begin
            if (col_end) begin
                slot_reg <= '0;
                if (last_col) begin
                    col_reg  <= '0;
                    cmod_reg <= '0;
                end else begin
                    col_reg  <= col_reg + ROW_W'(1);
                    cmod_reg <= (cmod_reg == IDX_LAST) ? '0 : cmod_reg + IDX_W'(1);
                end
            end else begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
        end
    end

    // stage 1: products and row sequencer
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_rr_reg, s1_ii_reg, s1_ri_reg, s1_ir_reg;
    logic                     s1_upd_reg, s1_rd_reg, s1_clr_reg;
    band_idx_t                s1_upd_id_reg, s1_rd_id_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [FLUSH_W-1:0]       s1_rem_reg;

    assign s1_done = !s1_valid_reg || (s1_rem_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_upd_reg   <= 1'b0;
            s1_rd_reg    <= 1'b0;
            s1_clr_reg   <= 1'b0;
            s1_rem_reg   <= '0;
        end else if (chain_adv) begin
            if (!s1_done) begin
                s1_rem_reg   <= s1_rem_reg - FLUSH_W'(1);
                s1_row_reg   <= s1_row_reg + ROW_W'(1);
                s1_rd_id_reg <= (s1_rd_id_reg == IDX_LAST) ? '0 : s1_rd_id_reg + IDX_W'(1);
                s1_upd_reg   <= 1'b0;
            end else begin
                s1_valid_reg <= s_valid;
                if (s_valid) begin
                    s1_rr_reg     <= s_a_re * s_x_re;
                    s1_ii_reg     <= s_a_im * s_x_im;
                    s1_ri_reg     <= s_a_re * s_x_im;
                    s1_ir_reg     <= s_a_im * s_x_re;
                    s1_upd_reg    <= upd_item;
                    s1_upd_id_reg <= upd_idx;
                    s1_rd_reg     <= rd_item;
                    s1_rd_id_reg  <= lo_idx;
                    s1_row_reg    <= lo_row;
                    s1_rem_reg    <= rem_item;
                    s1_clr_reg    <= col_end && last_col;
                end
            end
        end
    end

    // token injection
    logic signed [PROD_W:0] pre_re, pre_im;
    token_t                 inj_reg, inj_next;
    token_t                 tok_chain [MAX_BAND+1];

    assign pre_re = (PROD_W+1)'(s1_rr_reg) - (PROD_W+1)'(s1_ii_reg);
    assign pre_im = (PROD_W+1)'(s1_ri_reg) + (PROD_W+1)'(s1_ir_reg);

    always_comb begin
        inj_next          = '0;
        inj_next.upd      = s1_valid_reg && s1_upd_reg;
        inj_next.upd_id   = CELL_ID_W'(s1_upd_id_reg);
        inj_next.add_re   = ACC_W'(pre_re);
        inj_next.add_im   = ACC_W'(pre_im);
        inj_next.rd       = s1_valid_reg && s1_rd_reg;
        inj_next.rd_id    = CELL_ID_W'(s1_rd_id_reg);
        inj_next.row      = s1_row_reg;
        inj_next.last_row = s1_row_reg == nm1;
        inj_next.clr      = s1_valid_reg && s1_clr_reg && (s1_rem_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inj_reg <= '0;
        end else if (chain_adv) begin
            inj_reg <= inj_next;
        end
    end

    assign tok_chain[0] = inj_reg;

    for (genvar g = 0; g < MAX_BAND; g++) begin : g_cell
        cbmv_cell #(
            .CELL_NUM(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (chain_adv),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1])
        );
    end

    // output
    token_t  tail;
    result_t tail_res, out_res;
    logic    buf_ready;

    assign tail              = tok_chain[MAX_BAND];
    assign chain_adv         = !tail.rd || buf_ready;
    assign tail_res.row      = tail.row;
    assign tail_res.y_re     = tail.y_re;
    assign tail_res.y_im     = tail.y_im;
    assign tail_res.last_row = tail.last_row;

    cbmv_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tail.rd && buf_ready),
        .in_data   (tail_res),
        .in_ready  (buf_ready),
        .out_valid (m_valid),
        .out_data  (out_res),
        .out_ready (m_ready)
    );

    assign m_row_index = out_res.row;
    assign m_y_re      = out_res.y_re;
    assign m_y_im      = out_res.y_im;
    assign m_last_row  = out_res.last_row;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the complex band matrix-vector multiplier.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cbmv_pkg::*;

    localparam int MAX_BAND      = MAX_BAND_DEF;
    localparam int SETTLE_CYCLES = MAX_BAND + 16;
    localparam int TAIL_CYCLES   = 2 * MAX_BAND + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 250;
    localparam int BIG_SLOTS     = 30;
    localparam int LIMIT         = 2_000_000;

    typedef struct packed {
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] x_re;
        logic signed [15:0] x_im;
    } band_slot_t;

    typedef enum logic {STEP_SLOT, STEP_BAND} step_kind_t;

    typedef struct {
        step_kind_t kind;
        int         f0;
        int         f1;
        int         f2;
        int         f3;
        bit         given;
        result_t    want;
    } plan_step_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [15:0]           s_a_re = '0;
    logic signed [15:0]           s_a_im = '0;
    logic signed [15:0]           s_x_re = '0;
    logic signed [15:0]           s_x_im = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic        [ROW_W-1:0]      m_row_index;
    logic signed [ACC_W-1:0]      m_y_re;
    logic signed [ACC_W-1:0]      m_y_im;
    logic                         m_last_row;
    logic                         cfg_wr_en = 1'b0;
    logic        [CFG_IDX_W-1:0]  cfg_index = '0;
    logic        [CFG_DATA_W-1:0] cfg_wdata = '0;

    // band state mirrored from the block
    acc_t        y_acc_re [MAX_BAND] = '{default: '0};
    acc_t        y_acc_im [MAX_BAND] = '{default: '0};
    logic [15:0] col_idx = '0;
    logic [4:0]  slot_idx = '0;
    logic [16:0] band_n = 17'd1;
    logic [3:0]  band_lo = '0;
    logic [3:0]  band_up = '0;

    result_t     step_rows [$];
    result_t     expected_rows [$];

    int          s_idle_pct = 0;
    int          r_idle_pct = 0;
    logic        hold_request = 1'b0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          error_count = 0;
    int          rows_checked = 0;
    int          items_sent = 0;
    int          bands_programmed = 0;
    int          random_items = 0;

    plan_step_t directed_plan [0:30] = '{
        '{STEP_SLOT, 32767, 0, 32767, 0, 1'b1, '{16'd0, 40'sd1073676289, 40'sd0, 1'b1}},
        '{STEP_SLOT, -32768, 0, -32768, 0, 1'b1, '{16'd0, 40'sd1073741824, 40'sd0, 1'b1}},
        '{STEP_SLOT, -32768, -32768, -32768, -32768, 1'b1,
          '{16'd0, 40'sd0, 40'sd2147483648, 1'b1}},
        '{STEP_SLOT, 32767, -32768, -32768, 32767, 1'b1,
          '{16'd0, 40'sd0, 40'sd2147418113, 1'b1}},
        '{STEP_SLOT, -32768, 0, 32767, 0, 1'b1, '{16'd0, -40'sd1073709056, 40'sd0, 1'b1}},
        '{STEP_BAND, 0, 0, 0, 0, 1'b0, '0},
        '{STEP_SLOT, 1, -1, -1, 1, 1'b1, '{16'd0, 40'sd0, 40'sd2, 1'b1}},
        '{STEP_BAND, 4, 1, 1, 0, 1'b0, '0},
        '{STEP_SLOT, 100, 200, 12345, -2222, 1'b0, '0},
        '{STEP_SLOT, 32767, -32768, 12345, -2222, 1'b0, '0},
        '{STEP_SLOT, -1, 1, 12345, -2222, 1'b0, '0},
        '{STEP_SLOT, -32768, -32768, -32768, 32767, 1'b0, '0},
        '{STEP_SLOT, 7, -9, -32768, 32767, 1'b0, '0},
        '{STEP_SLOT, 32767, 32767, -32768, 32767, 1'b0, '0},
        '{STEP_SLOT, -300, 400, 1, 0, 1'b0, '0},
        '{STEP_SLOT, 0, 0, 1, 0, 1'b0, '0},
        '{STEP_SLOT, 5000, -6000, 1, 0, 1'b0, '0},
        '{STEP_SLOT, 11, 22, -1, -1, 1'b0, '0},
        '{STEP_SLOT, -32768, 32767, -1, -1, 1'b0, '0},
        '{STEP_SLOT, 999, -999, -1, -1, 1'b0, '0},
        '{STEP_BAND, 8, 0, 0, 0, 1'b0, '0},
        '{STEP_SLOT, 1234, -4321, 2000, 3000, 1'b0, '0},
        '{STEP_SLOT, -5555, 6666, -7000, 8000, 1'b0, '0},
        '{STEP_BAND, 1, 0, 0, 0, 1'b0, '0},
        '{STEP_SLOT, 32767, 32767, 32767, 32767, 1'b0, '0},
        '{STEP_SLOT, 300, -300, 400, 500, 1'b0, '0},
        '{STEP_BAND, 8, 1, 0, 0, 1'b0, '0},
        '{STEP_SLOT, 2, 3, 4, 5, 1'b0, '0},
        '{STEP_SLOT, -6, 7, 4, 5, 1'b0, '0},
        '{STEP_BAND, 8, 0, 0, 0, 1'b0, '0},
        '{STEP_SLOT, 9, -10, 11, -12, 1'b0, '0}
    };

    complex_band_matrix_vector_multiply u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_a_re      (s_a_re),
        .s_a_im      (s_a_im),
        .s_x_re      (s_x_re),
        .s_x_im      (s_x_im),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_index (m_row_index),
        .m_y_re      (m_y_re),
        .m_y_im      (m_y_im),
        .m_last_row  (m_last_row),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void mac_slot(input band_slot_t word);
        int      order;
        int      col;
        int      row;
        int      lo;
        int      hi;
        int      width;
        int      k;
        bit      closing;
        longint  p_re;
        longint  p_im;
        result_t done;
        step_rows.delete();
        if (band_n == 17'd0) order = 1;
        else if (band_n > 17'd65536) order = 65536;
        else order = int'(band_n);
        col = int'(col_idx);
        width = int'(band_lo) + int'(band_up) + 1;
        row = col - int'(band_up) + int'(slot_idx);
        if (row >= 0 && row < order) begin
            p_re = longint'($signed(word.a_re)) * longint'($signed(word.x_re))
                 - longint'($signed(word.a_im)) * longint'($signed(word.x_im));
            p_im = longint'($signed(word.a_re)) * longint'($signed(word.x_im))
                 + longint'($signed(word.a_im)) * longint'($signed(word.x_re));
            k = row % MAX_BAND;
            y_acc_re[k] = y_acc_re[k] + p_re[ACC_W-1:0];
            y_acc_im[k] = y_acc_im[k] + p_im[ACC_W-1:0];
        end
        if (int'(slot_idx) + 1 >= width) begin
            closing = (col >= order - 1);
            lo = col - int'(band_up);
            hi = closing ? order - 1 : lo;
            if (lo < 0) lo = 0;
            for (int r = lo; r <= hi && step_rows.size() < 16; r++) begin
                k = r % MAX_BAND;
                done.row = ROW_W'(r);
                done.y_re = y_acc_re[k];
                done.y_im = y_acc_im[k];
                done.last_row = (r == order - 1);
                step_rows.push_back(done);
                y_acc_re[k] = '0;
                y_acc_im[k] = '0;
            end
            slot_idx = '0;
            if (closing) begin
                foreach (y_acc_re[i]) begin
                    y_acc_re[i] = '0;
                    y_acc_im[i] = '0;
                end
                col_idx = '0;
            end else begin
                col_idx = col_idx + 16'd1;
            end
        end else begin
            slot_idx = slot_idx + 5'd1;
        end
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endtask

    task automatic send_slot(input band_slot_t word, input bit given, input result_t want);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_a_re  <= word.a_re;
        s_a_im  <= word.a_im;
        s_x_re  <= word.x_re;
        s_x_im  <= word.x_im;
        do @(posedge aclk); while (!s_ready);
        mac_slot(word);
        if (given) expected_rows.push_back(want);
        else foreach (step_rows[i]) expected_rows.push_back(step_rows[i]);
        items_sent++;
    endtask

    task automatic drain_rows();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_rows.size() != 0);
    endtask

    task automatic quiesce();
        drain_rows();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_band(input logic [16:0] n, input logic [3:0] lo, input logic [3:0] up);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_N_SIZE;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_index <= REG_LOWER_BW;
        cfg_wdata <= CFG_DATA_W'(lo);
        @(posedge aclk);
        cfg_index <= REG_UPPER_BW;
        cfg_wdata <= CFG_DATA_W'(up);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        band_n = n;
        band_lo = lo;
        band_up = up;
        bands_programmed++;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            stall_left = HOLD_CYCLES - 1;
            hold_request <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= r_idle_pct);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            rows_checked++;
            if (expected_rows.size() == 0) begin
                note_mismatch($sformatf("unexpected row %0d y=(%0d,%0d) last %0b",
                    m_row_index, m_y_re, m_y_im, m_last_row));
            end else begin
                want = expected_rows.pop_front();
                if (m_row_index !== want.row || m_y_re !== want.y_re ||
                    m_y_im !== want.y_im || m_last_row !== want.last_row) begin
                    note_mismatch($sformatf(
                        "expected row %0d y=(%0d,%0d) last %0b, got row %0d y=(%0d,%0d) last %0b",
                        want.row, want.y_re, want.y_im, want.last_row,
                        m_row_index, m_y_re, m_y_im, m_last_row));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        plan_step_t         step;
        band_slot_t         word;
        int                 n;
        int                 lo;
        int                 up;
        int                 m;
        int                 cut;
        bit                 broken;
        bit                 noisy;
        logic signed [15:0] xr;
        logic signed [15:0] xi;
        logic [16:0]        big_n;

        s_idle_pct = 33;
        r_idle_pct = 66;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            step = directed_plan[i];
            if (step.kind == STEP_BAND) begin
                quiesce();
                program_band(17'(step.f0), 4'(step.f1), 4'(step.f2));
            end else begin
                word = '{16'(step.f0), 16'(step.f1), 16'(step.f2), 16'(step.f3)};
                send_slot(word, step.given, step.want);
            end
        end

        while (random_items < RANDOM_ITEMS) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                s_idle_pct = 33;
                r_idle_pct = 66;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                s_idle_pct = 66;
                r_idle_pct = 33;
            end else begin
                s_idle_pct = 0;
                r_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0: begin
                    n = $urandom_range(1, 3);
                    lo = 15;
                    up = 15;
                end
                1: begin
                    n = $urandom_range(33, 45);
                    lo = $urandom_range(0, 1);
                    up = $urandom_range(0, 1);
                end
                2: begin
                    n = 1;
                    lo = $urandom_range(0, 15);
                    up = $urandom_range(0, 15);
                end
                default: begin
                    n = $urandom_range(2, 10);
                    lo = $urandom_range(0, 7);
                    up = $urandom_range(0, 7);
                end
            endcase
            m = lo + up + 1;
            quiesce();
            program_band(17'(n), 4'(lo), 4'(up));
            broken = ($urandom_range(0, 7) == 0);
            noisy = ($urandom_range(0, 5) == 0);
            cut = broken ? $urandom_range(1, n * m - 1 + (n * m == 1)) : n * m;
            xr = pick_sample();
            xi = pick_sample();
            for (int k = 0; k < cut; k++) begin
                if (k % m == 0 || noisy) begin
                    xr = pick_sample();
                    xi = pick_sample();
                end
                if (k % m == 0 && k != 0 && $urandom_range(0, 24) == 0) drain_rows();
                word = '{pick_sample(), pick_sample(), xr, xi};
                send_slot(word, 1'b0, '0);
            end
            random_items += cut;
            if (broken) begin
                // realign: a one-slot band of order one closes the vector
                quiesce();
                program_band(17'd1, 4'd0, 4'd0);
                word = '{pick_sample(), pick_sample(), pick_sample(), pick_sample()};
                send_slot(word, 1'b0, '0);
                random_items++;
            end
        end

        // stall the result side while slots keep coming
        quiesce();
        program_band(17'd100, 4'd0, 4'd0);
        for (int k = 0; k < 100; k++) begin
            if (k == 10) hold_request <= 1'b1;
            if (k == 70) drain_rows();
            word = '{pick_sample(), pick_sample(), pick_sample(), pick_sample()};
            send_slot(word, 1'b0, '0);
        end

        // order at and above the top clamps to the full row range
        for (int j = 0; j < 2; j++) begin
            big_n = (j == 0) ? 17'h10000 : 17'h1FFFF;
            quiesce();
            program_band(big_n, 4'd1, 4'd1);
            for (int k = 0; k < BIG_SLOTS; k++) begin
                word = '{pick_sample(), pick_sample(), pick_sample(), pick_sample()};
                send_slot(word, 1'b0, '0);
            end
            quiesce();
            program_band(17'd1, 4'd0, 4'd0);
            word = '{pick_sample(), pick_sample(), pick_sample(), pick_sample()};
            send_slot(word, 1'b0, '0);
        end

        drain_rows();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_rows.size() != 0)
            note_mismatch($sformatf("%0d rows never produced", expected_rows.size()));
        $display("Run covered %0d band slots under %0d band settings; %0d rows of y checked.",
            items_sent, bands_programmed, rows_checked);
        $display("Mismatches: %0d, cycles: %0d.", error_count, cycle_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
